>>> hdl/scd_pkg.sv
// ----------------------------------------------------------------------------
// scd_pkg
// Shared types and constants for the SD clock divider code block.
// ----------------------------------------------------------------------------
`default_nettype none

package scd_pkg;

	localparam int unsigned DATA_W     = 32;
	localparam int unsigned CELL_COUNT = DATA_W;
	localparam int unsigned CODE_W     = 10;
	localparam int unsigned CTRL_W     = 16;
	localparam int unsigned PADDR_W    = 3;
	localparam int unsigned PDATA_W    = 32;

	localparam logic [CODE_W-1:0]  CODE_MAX   = 10'h3FF;
	localparam logic [CODE_W:0]    QUOT_LIMIT = 11'h400;

	// register index, taken from paddr[2]
	localparam logic REG_BASE_CLOCK = 1'b0;

	typedef struct packed {
		logic              vld;
		logic              force_max;
		logic              force_zero;
		logic [DATA_W-1:0] rem;
		logic [DATA_W-1:0] dq;
		logic [DATA_W-1:0] dvs;
	} scd_cell_t;

endpackage

`default_nettype wire

>>> hdl/scd_chan_if.sv
// ----------------------------------------------------------------------------
// scd_target_if / scd_ctrl_if
// Valid/ready channels for target rate requests and control-bit results.
// ----------------------------------------------------------------------------
`default_nettype none

interface scd_target_if;
	logic        valid;
	logic        ready;
	logic [31:0] target_rate_hz;

	modport source (output valid, output target_rate_hz, input ready);
	modport sink   (input valid, input target_rate_hz, output ready);
endinterface

interface scd_ctrl_if;
	logic        valid;
	logic        ready;
	logic [15:0] clock_control_bits;

	modport source (output valid, output clock_control_bits, input ready);
	modport sink   (input valid, input clock_control_bits, output ready);
endinterface

`default_nettype wire

>>> hdl/scd_div_cell.sv
// ----------------------------------------------------------------------------
// scd_div_cell
// One restoring division step: shifts in a dividend bit, retires a quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module scd_div_cell
	import scd_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      en,
	input  wire scd_cell_t d,
	output scd_cell_t      q
);

	logic [DATA_W:0]   trial;
	logic [DATA_W:0]   diff;
	logic              qbit;
	scd_cell_t         nxt;

	always_comb begin
		trial          = {d.rem, d.dq[DATA_W-1]};
		diff           = trial - {1'b0, d.dvs};
		qbit           = ~diff[DATA_W];
		nxt            = d;
		nxt.rem        = qbit ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
		nxt.dq         = {d.dq[DATA_W-2:0], qbit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q <= nxt;
		end
	end

endmodule

`default_nettype wire

>>> hdl/scd_pack_stage.sv
// ----------------------------------------------------------------------------
// scd_pack_stage
// Turns quotient and remainder into the divider code and packs the result.
// ----------------------------------------------------------------------------
`default_nettype none

module scd_pack_stage
	import scd_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire scd_cell_t       d,
	output logic                 vld_q,
	output logic [CTRL_W-1:0]    bits_q
);

	logic [CODE_W-1:0] v;
	logic [CODE_W-1:0] code;
	logic              exact;
	logic              big;

	always_comb begin
		exact = (d.rem == '0);
		big   = (d.dq > {{(DATA_W-CODE_W-1){1'b0}}, QUOT_LIMIT});
		// smear q-1 to 2^e-1, code is 2^(e-1)
		v     = d.dq[CODE_W-1:0] - 1'b1;
		v     = v | (v >> 1);
		v     = v | (v >> 2);
		v     = v | (v >> 4);
		v     = v | (v >> 8);
		if (d.force_max) begin
			code = CODE_MAX;
		end else if (d.force_zero) begin
			code = '0;
		end else if (!exact || big) begin
			code = CODE_MAX;
		end else if (v == '0) begin
			code = '0;
		end else begin
			code = (v >> 1) + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= 1'b0;
			bits_q <= '0;
		end else if (en) begin
			vld_q  <= d.vld;
			bits_q <= {code[7:0], code[9:8], 6'b0};
		end
	end

endmodule

`default_nettype wire

>>> hdl/sd_clock_divider_code.sv
// ----------------------------------------------------------------------------
// sd_clock_divider_code
// SD host clock divider select: base clock / target rate to control bits.
// ----------------------------------------------------------------------------
// Pipeline: a result passes 32 divide cells and then the pack stage; the first
// cell loads on the accepting edge.
// Throughput: one request per cycle while the result is not stalled.
// A stalled result freezes the whole cell chain; ready drops until taken.
// Reset clears all stage valid flags and sets base_clock_hz to 0.
`default_nettype none

module sd_clock_divider_code
	import scd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	scd_target_if.sink              request,
	scd_ctrl_if.source              response
);

	logic [DATA_W-1:0] base_q;
	logic              en;
	scd_cell_t         head;
	scd_cell_t         chain [CELL_COUNT+1];

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == REG_BASE_CLOCK) begin
			base_q <= pwdata;
		end
	end

	assign prdata = (paddr[2] == REG_BASE_CLOCK) ? base_q : '0;

	assign en            = !response.valid || response.ready;
	assign request.ready = en;

	always_comb begin
		head            = '0;
		head.vld        = request.valid;
		head.force_max  = (request.target_rate_hz == '0);
		head.force_zero = (request.target_rate_hz > base_q);
		head.rem        = '0;
		head.dq         = base_q;
		head.dvs        = request.target_rate_hz;
	end

	assign chain[0] = head;

	for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
		scd_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.d      (chain[i]),
			.q      (chain[i+1])
		);
	end

	scd_pack_stage u_pack (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.d      (chain[CELL_COUNT]),
		.vld_q  (response.valid),
		.bits_q (response.clock_control_bits)
	);

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		response.valid && !response.ready |-> !request.ready)
		else $error("request taken while result stalled");

	a_enter_chain: assert property (@(posedge clk) disable iff (!arst_n)
		request.valid && request.ready |=> chain[1].vld)
		else $error("accepted request missing from first cell");

	a_reach_out: assert property (@(posedge clk) disable iff (!arst_n)
		en && chain[CELL_COUNT].vld |=> response.valid)
		else $error("last cell result not delivered");

	a_low_bits: assert property (@(posedge clk) disable iff (!arst_n)
		response.valid |-> response.clock_control_bits[5:0] == 6'b0)
		else $error("reserved control bits set");

endmodule

`default_nettype wire

>>> sim/sd_clock_divider_code_tb.sv
// ----------------------------------------------------------------------------
// sd_clock_divider_code_tb
// Self-checking bench for the SD host clock divider select block. Requests of
// target rate are checked against a table or a divider-code predictor; the base
// clock register is written over APB between phases and read back each time.
// ----------------------------------------------------------------------------
module sd_clock_divider_code_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import scd_pkg::*;

	localparam int RESULT_LATENCY = 33;
	localparam int SETTLE_CYCLES  = RESULT_LATENCY + 16;
	localparam int PHASES         = 10;
	localparam int PHASE_ITEMS    = 70;
	localparam int LONG_HOLD      = 300;
	localparam int MAX_REPORTS    = 10;
	localparam int DIR_ROWS       = 23;

	localparam logic [PADDR_W-1:0] ADDR_BASE_CLOCK = {REG_BASE_CLOCK, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_UNUSED     = {~REG_BASE_CLOCK, 2'b00};

	localparam logic [CTRL_W-1:0] CTRL_UNDIVIDED = 16'h0000;
	localparam logic [CTRL_W-1:0] CTRL_MAX       = 16'hFFC0;

	typedef struct packed {
		logic [DATA_W-1:0] base;
		logic [DATA_W-1:0] target;
		logic              known;
		logic [CTRL_W-1:0] ctrl;
	} dir_row_t;

	typedef struct packed {
		logic [DATA_W-1:0] base;
		logic [DATA_W-1:0] target;
		logic [CTRL_W-1:0] ctrl;
	} ctrl_expect_t;

	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		'{32'd0,          32'd0,          1'b1, CTRL_MAX},
		'{32'd0,          32'd1,          1'b1, CTRL_UNDIVIDED},
		'{32'd0,          32'hFFFF_FFFF,  1'b1, CTRL_UNDIVIDED},
		'{32'd100000000,  32'd400000,     1'b1, 16'h8000},
		'{32'd100000000,  32'd25000000,   1'b1, 16'h0200},
		'{32'd100000000,  32'd100000000,  1'b1, CTRL_UNDIVIDED},
		'{32'd100000000,  32'd200000000,  1'b1, CTRL_UNDIVIDED},
		'{32'd100000000,  32'd300000,     1'b1, CTRL_MAX},
		'{32'd100000000,  32'd50000000,   1'b1, 16'h0100},
		'{32'd100000000,  32'd1,          1'b1, CTRL_MAX},
		'{32'd100000000,  32'd0,          1'b1, CTRL_MAX},
		'{32'd100000000,  32'd12500000,   1'b0, '0},
		'{32'h4000_0000,  32'h0010_0000,  1'b1, 16'h0080},
		'{32'h4000_0000,  32'h0008_0000,  1'b1, CTRL_MAX},
		'{32'h4000_0000,  32'h0020_0000,  1'b1, 16'h0040},
		'{32'h4000_0000,  32'h0200_0000,  1'b0, '0},
		'{32'd3000000,    32'd1000000,    1'b1, 16'h0200},
		'{32'd3000000,    32'd3000,       1'b0, '0},
		'{32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, CTRL_UNDIVIDED},
		'{32'hFFFF_FFFF,  32'd1,          1'b1, CTRL_MAX},
		'{32'hFFFF_FFFF,  32'hFFFF_FFFE,  1'b1, CTRL_MAX},
		'{32'hFFFF_FFFF,  32'h5555_5555,  1'b0, '0},
		'{32'hFFFF_FFFF,  32'h0101_0101,  1'b0, '0}
	};

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	scd_target_if req_if();
	scd_ctrl_if   rsp_if();

	sd_clock_divider_code u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.request  (req_if),
		.response (rsp_if)
	);

	ctrl_expect_t      ctrl_expect_q [$];
	ctrl_expect_t      ctrl_head;
	logic [DATA_W-1:0] cfg_base;
	int                mismatches = 0;
	bit                idle_en = 1'b1;
	int                hold_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("sd_clock_divider_code verification failed");
		$finish;
	end

	function automatic logic [CTRL_W-1:0] divider_ctrl_bits(input logic [DATA_W-1:0] base,
			input logic [DATA_W-1:0] target);
		logic [DATA_W-1:0] quot;
		logic [CODE_W-1:0] code;
		int                top;
		int                expo;
		top = 0;
		if (target == '0) begin
			code = CODE_MAX;
		end else if (target > base) begin
			code = '0;
		end else if ((base % target) != '0) begin
			code = CODE_MAX;
		end else begin
			quot = base / target;
			for (int b = 0; b < DATA_W; b++)
				if (quot[b]) top = b;
			expo = top + (((quot & (quot - 1)) != '0) ? 1 : 0);
			if (expo == 0)
				code = '0;
			else if (quot > QUOT_LIMIT)
				code = CODE_MAX;
			else
				code = CODE_W'(1 << (expo - 1));
		end
		return {code[7:0], code[9:8], 6'b0};
	endfunction

	// mostly exact divisors of a base built as mult << shift
	function automatic logic [DATA_W-1:0] pick_target(input logic [DATA_W-1:0] base,
			input int shift, input int mult);
		int                sel;
		int                i;
		logic [DATA_W-1:0] t;
		sel = $urandom_range(0, 99);
		if (sel < 40) begin
			i = $urandom_range(0, (shift > 12) ? 12 : shift);
			t = base >> i;
		end else if (sel < 55) begin
			i = $urandom_range(0, shift);
			t = (base >> i) / mult;
		end else if (sel < 65) begin
			t = base / $urandom_range(1, 2048);
		end else if (sel < 75) begin
			if (base == '1)
				t = $urandom;
			else
				t = base + $urandom_range(1, ~base);
		end else if (sel < 80) begin
			t = '0;
		end else begin
			t = $urandom;
		end
		return t;
	endfunction

	task automatic note_mismatch(input string what, input logic [DATA_W-1:0] expv,
			input logic [DATA_W-1:0] actv);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("MISMATCH %s: expected %h, got %h", what, expv, actv);
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (ctrl_expect_q.size() == 0) begin
				note_mismatch("unexpected result", '0,
					DATA_W'(rsp_if.clock_control_bits));
			end else begin
				ctrl_head = ctrl_expect_q.pop_front();
				if (rsp_if.clock_control_bits !== ctrl_head.ctrl) begin
					if (mismatches < MAX_REPORTS)
						$display("  base %h target %h", ctrl_head.base, ctrl_head.target);
					note_mismatch("clock_control_bits", DATA_W'(ctrl_head.ctrl),
						DATA_W'(rsp_if.clock_control_bits));
				end
			end
		end
	end

	initial begin
		rsp_if.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
				rsp_if.ready <= 1'b1;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				rsp_if.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
				rsp_if.ready <= 1'b1;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
			input logic [PDATA_W-1:0] wdata, output logic [PDATA_W-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_base_readback();
		logic [PDATA_W-1:0] rd;
		apb_access(1'b0, ADDR_BASE_CLOCK, '0, rd);
		if (rd !== cfg_base)
			note_mismatch("base_clock_hz readback", cfg_base, rd);
	endtask

	task automatic set_base(input logic [DATA_W-1:0] value);
		logic [PDATA_W-1:0] rd;
		apb_access(1'b1, ADDR_BASE_CLOCK, value, rd);
		cfg_base = value;
		check_base_readback();
	endtask

	task automatic send_target(input logic [DATA_W-1:0] target, input logic known,
			input logic [CTRL_W-1:0] ctrl);
		ctrl_expect_t rec;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		req_if.valid          <= 1'b1;
		req_if.target_rate_hz <= target;
		do @(posedge clk); while (!req_if.ready);
		rec.base   = cfg_base;
		rec.target = target;
		rec.ctrl   = known ? ctrl : divider_ctrl_bits(cfg_base, target);
		ctrl_expect_q.push_back(rec);
	endtask

	task automatic drain_results();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (ctrl_expect_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [PDATA_W-1:0] rd;
		logic [DATA_W-1:0]  base_next;
		int                 shift;
		int                 mult;
		arst_n                = 1'b0;
		psel                  = 1'b0;
		penable               = 1'b0;
		pwrite                = 1'b0;
		paddr                 = '0;
		pwdata                = '0;
		req_if.valid          = 1'b0;
		req_if.target_rate_hz = '0;
		cfg_base              = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_base_readback();

		for (int r = 0; r < DIR_ROWS; r++) begin
			if (DIR_TABLE[r].base != cfg_base) begin
				drain_results();
				set_base(DIR_TABLE[r].base);
			end
			send_target(DIR_TABLE[r].target, DIR_TABLE[r].known, DIR_TABLE[r].ctrl);
		end
		drain_results();

		// write to an unmapped register must leave the base clock alone
		apb_access(1'b1, ADDR_UNUSED, $urandom, rd);
		check_base_readback();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					base_next = '1;
					mult      = 255;
					shift     = 0;
				end
				1: begin
					base_next = '0;
					mult      = 1;
					shift     = 0;
				end
				3: begin
					base_next = $urandom;
					mult      = 1;
					shift     = 0;
				end
				default: begin
					mult      = $urandom_range(1, 1000);
					shift     = $urandom_range(0, 22);
					base_next = mult << shift;
				end
			endcase
			set_base(base_next);
			idle_en = (phase != PHASES - 1);
			if (phase == 2)
				hold_cycles = LONG_HOLD;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (phase == 5 && n == PHASE_ITEMS / 2)
					drain_results();
				send_target(pick_target(cfg_base, shift, mult), 1'b0, '0);
			end
			drain_results();
		end

		if (mismatches == 0 && ctrl_expect_q.size() == 0)
			$display("sd_clock_divider_code verification clean");
		else
			$display("sd_clock_divider_code verification failed");
		$finish;
	end

endmodule

>>> files.f
hdl/scd_pkg.sv
hdl/scd_chan_if.sv
hdl/scd_div_cell.sv
hdl/scd_pack_stage.sv
hdl/sd_clock_divider_code.sv
sim/sd_clock_divider_code_tb.sv
